// ===== hw/rtl/ihpq_pkg.sv =====
package ihpq_pkg;

  // Default sizes
  localparam int unsigned HeapCapacityDef = 256;
  localparam int unsigned UserCountDef    = 256;
  localparam int unsigned ValueBitsDef    = 32;

  // Field widths
  localparam int unsigned OpW   = 2;
  localparam int unsigned IdW   = 8;
  localparam int unsigned NumW  = 32;
  localparam int unsigned StatW = 2;
  localparam int unsigned OccW  = 9;
  localparam int unsigned IdCount = 1 << IdW;

  // Operation codes
  localparam logic [OpW-1:0] OP_INSERT  = 2'd0;
  localparam logic [OpW-1:0] OP_EXTRACT = 2'd1;
  localparam logic [OpW-1:0] OP_CHANGE  = 2'd2;

  // Status codes
  localparam logic [StatW-1:0] ST_OK     = 2'd0;
  localparam logic [StatW-1:0] ST_EMPTY  = 2'd1;
  localparam logic [StatW-1:0] ST_FULL   = 2'd2;
  localparam logic [StatW-1:0] ST_ABSENT = 2'd3;

endpackage

// ===== hw/rtl/ihpq_if.sv =====
// Command channel
interface ihpq_in_if;
  logic                                 valid;
  logic                                 ready;
  logic        [ihpq_pkg::OpW-1:0]      operation;
  logic        [ihpq_pkg::IdW-1:0]      user_id;
  logic        [ihpq_pkg::IdW-1:0]      partner_id;
  logic signed [ihpq_pkg::NumW-1:0]     new_value;
  logic signed [ihpq_pkg::NumW-1:0]     amount;
  modport source (output valid, operation, user_id, partner_id, new_value, amount,
                  input ready);
  modport sink   (input valid, operation, user_id, partner_id, new_value, amount,
                  output ready);
endinterface

// Result channel
interface ihpq_out_if;
  logic                                 valid;
  logic                                 ready;
  logic        [ihpq_pkg::StatW-1:0]    status;
  logic        [ihpq_pkg::IdW-1:0]      out_user;
  logic        [ihpq_pkg::IdW-1:0]      out_partner;
  logic signed [ihpq_pkg::NumW-1:0]     out_value;
  logic        [ihpq_pkg::OccW-1:0]     occupancy;
  modport source (output valid, status, out_user, out_partner, out_value, occupancy,
                  input ready);
  modport sink   (input valid, status, out_user, out_partner, out_value, occupancy,
                  output ready);
endinterface

// ===== hw/rtl/ihpq_heap_ram.sv =====
// Heap storage: two registered read ports, one write port
module ihpq_heap_ram #(
  parameter int unsigned Depth = ihpq_pkg::HeapCapacityDef,
  parameter int unsigned AddrW = $clog2(Depth),
  parameter int unsigned DataW = 48
) (
  input  logic             clk_i,
  input  logic [AddrW-1:0] rd_a_addr_i,
  output logic [DataW-1:0] rd_a_data_o,
  input  logic [AddrW-1:0] rd_b_addr_i,
  output logic [DataW-1:0] rd_b_data_o,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [DataW-1:0] wr_data_i
);

  logic [DataW-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_a_data_o <= mem[rd_a_addr_i];
    rd_b_data_o <= mem[rd_b_addr_i];
  end

endmodule

// ===== hw/rtl/ihpq_map_ram.sv =====
// Position map storage: one registered read port, one write port
module ihpq_map_ram #(
  parameter int unsigned Depth = ihpq_pkg::UserCountDef,
  parameter int unsigned AddrW = $clog2(Depth),
  parameter int unsigned DataW = 9
) (
  input  logic             clk_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [DataW-1:0] rd_data_o,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [DataW-1:0] wr_data_i
);

  logic [DataW-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_o <= mem[rd_addr_i];
  end

endmodule

// ===== hw/rtl/indexed_max_heap_priority_queue.sv =====
// Channel | Dir | Fields
// in_i    | in  | operation, user_id, partner_id, new_value, amount
// out_o   | out | status, out_user, out_partner, out_value, occupancy
//
// One command at a time. Sift up or down handles each heap level as a
// compare and swap, then a second map update with the next read. Errors
// (empty, full, unused code) go straight to the finish state; an absent
// user is reported after the position map read.
// After reset the position map is swept clear, with in_i.ready low.
// A finished result waits in an output register; the next command is taken
// meanwhile and stalls only at its own end if that register is still full.
module indexed_max_heap_priority_queue #(
  parameter int unsigned HEAP_CAPACITY = ihpq_pkg::HeapCapacityDef,
  parameter int unsigned USER_COUNT    = ihpq_pkg::UserCountDef,
  parameter int unsigned VALUE_BITS    = ihpq_pkg::ValueBitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  ihpq_in_if.sink    in_i,
  ihpq_out_if.source out_o
);

  localparam int unsigned SW  = $clog2(HEAP_CAPACITY);
  localparam int unsigned CW  = $clog2(HEAP_CAPACITY + 1);
  localparam int unsigned LW  = SW + 2;
  localparam int unsigned UW  = $clog2(USER_COUNT);
  localparam int unsigned VB  = VALUE_BITS;
  localparam int unsigned IW  = ihpq_pkg::IdW;
  localparam int unsigned HW  = 2 * IW + VB;
  localparam int unsigned MW  = SW + 1;
  localparam int unsigned DW  = ((VB > ihpq_pkg::NumW) ? VB : ihpq_pkg::NumW) + 1;
  localparam logic signed [DW-1:0] VMAX_D = {{(DW-VB+1){1'b0}}, {(VB-1){1'b1}}};
  localparam logic signed [DW-1:0] VMIN_D = {{(DW-VB+1){1'b1}}, {(VB-1){1'b0}}};
  localparam logic [CW-1:0] CAP_C = CW'(HEAP_CAPACITY);
  localparam logic [UW-1:0] ULAST = UW'(USER_COUNT - 1);

  // States
  localparam logic [3:0] S_CLR     = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_EXT_RD  = 4'd2;
  localparam logic [3:0] S_EXT_REC = 4'd3;
  localparam logic [3:0] S_CHG_MAP = 4'd4;
  localparam logic [3:0] S_CHG_RD  = 4'd5;
  localparam logic [3:0] S_UP_RD   = 4'd6;
  localparam logic [3:0] S_UP_W2   = 4'd7;
  localparam logic [3:0] S_DN_RD   = 4'd8;
  localparam logic [3:0] S_DN_W2   = 4'd9;
  localparam logic [3:0] S_FIN     = 4'd10;

  function automatic logic signed [VB-1:0] sat_f(input logic signed [DW-1:0] x);
    logic signed [DW-1:0] c;
    c = x;
    if (x > VMAX_D) c = VMAX_D;
    else if (x < VMIN_D) c = VMIN_D;
    return c[VB-1:0];
  endfunction

  // User id to map index, user % USER_COUNT, fixed at elaboration
  logic [UW-1:0] idx_tab [ihpq_pkg::IdCount];
  for (genvar g = 0; g < ihpq_pkg::IdCount; g++) begin : g_idx
    assign idx_tab[g] = UW'(g % USER_COUNT);
  end

  // Memory ports
  logic [SW-1:0] hr_a_addr, hr_b_addr, hw_addr;
  logic [HW-1:0] hr_a_data, hr_b_data, hw_data;
  logic          hw_en;
  logic [UW-1:0] mr_addr, mw_addr;
  logic [MW-1:0] mr_data, mw_data;
  logic          mw_en;

  ihpq_heap_ram #(.Depth(HEAP_CAPACITY), .AddrW(SW), .DataW(HW)) u_heap (
    .clk_i, .rd_a_addr_i(hr_a_addr), .rd_a_data_o(hr_a_data),
    .rd_b_addr_i(hr_b_addr), .rd_b_data_o(hr_b_data),
    .wr_en_i(hw_en), .wr_addr_i(hw_addr), .wr_data_i(hw_data)
  );

  ihpq_map_ram #(.Depth(USER_COUNT), .AddrW(UW), .DataW(MW)) u_map (
    .clk_i, .rd_addr_i(mr_addr), .rd_data_o(mr_data),
    .wr_en_i(mw_en), .wr_addr_i(mw_addr), .wr_data_i(mw_data)
  );

  // Control and datapath registers
  logic [3:0]                state_q, state_d;
  logic [UW-1:0]             clr_q, clr_d;
  logic [CW-1:0]             cnt_q, cnt_d;
  logic [SW-1:0]             slot_q, slot_d;
  logic [SW-1:0]             sw_slot_q, sw_slot_d;
  logic [IW-1:0]             sw_user_q, sw_user_d;
  logic [IW-1:0]             mv_user_q, mv_user_d;
  logic [IW-1:0]             mv_part_q, mv_part_d;
  logic signed [VB-1:0]      mv_val_q, mv_val_d;
  logic                      wr_mv_q, wr_mv_d;
  logic signed [ihpq_pkg::NumW-1:0] amt_q, amt_d;
  logic [ihpq_pkg::StatW-1:0] st_q, st_d;
  logic [IW-1:0]             ru_q, ru_d, rp_q, rp_d;
  logic signed [ihpq_pkg::NumW-1:0] rv_q, rv_d;
  logic                      ov_q, ov_d;
  logic [ihpq_pkg::StatW-1:0] o_st_q, o_st_d;
  logic [IW-1:0]             o_u_q, o_u_d, o_p_q, o_p_d;
  logic signed [ihpq_pkg::NumW-1:0] o_v_q, o_v_d;
  logic [ihpq_pkg::OccW-1:0] o_occ_q, o_occ_d;

  // Read data fields
  logic [IW-1:0]        a_user, b_user;
  logic signed [VB-1:0] a_val, b_val;
  logic [IW-1:0]        a_part;
  assign a_user = hr_a_data[HW-1 -: IW];
  assign a_part = hr_a_data[VB +: IW];
  assign a_val  = hr_a_data[VB-1:0];
  assign b_user = hr_b_data[HW-1 -: IW];
  assign b_val  = hr_b_data[VB-1:0];

  // Helpers
  logic [SW-1:0]        up_slot;
  logic [LW-1:0]        lc, rc, cntx;
  logic signed [DW-1:0] diff;
  logic signed [VB-1:0] nw;
  logic                 l_ok, r_ok, pick_l, pick_r;
  logic signed [VB-1:0] best_val;
  logic [LW-1:0]        lc_n;

  assign up_slot = SW'((slot_q - SW'(1)) >> 1);
  assign lc      = {1'b0, slot_q, 1'b1};
  assign rc      = lc + LW'(1);
  assign cntx    = LW'(cnt_q);
  assign l_ok    = lc < cntx;
  assign r_ok    = rc < cntx;
  assign pick_l  = l_ok && (a_val > mv_val_q);
  assign best_val = pick_l ? a_val : mv_val_q;
  assign pick_r  = r_ok && (b_val > best_val);
  assign diff    = DW'(a_val) - DW'(amt_q);
  assign nw      = sat_f(diff);

  assign in_i.ready = (state_q == S_IDLE);
  assign out_o.valid       = ov_q;
  assign out_o.status      = o_st_q;
  assign out_o.out_user    = o_u_q;
  assign out_o.out_partner = o_p_q;
  assign out_o.out_value   = o_v_q;
  assign out_o.occupancy   = o_occ_q;

  // Sequencer
  always_comb begin
    state_d = state_q;   clr_d = clr_q;     cnt_d = cnt_q;
    slot_d = slot_q;     sw_slot_d = sw_slot_q; sw_user_d = sw_user_q;
    mv_user_d = mv_user_q; mv_part_d = mv_part_q; mv_val_d = mv_val_q;
    wr_mv_d = wr_mv_q;   amt_d = amt_q;     st_d = st_q;
    ru_d = ru_q;         rp_d = rp_q;       rv_d = rv_q;
    ov_d = ov_q;         o_st_d = o_st_q;   o_u_d = o_u_q;
    o_p_d = o_p_q;       o_v_d = o_v_q;     o_occ_d = o_occ_q;
    hr_a_addr = '0;      hr_b_addr = '0;
    hw_en = 1'b0;        hw_addr = slot_q;  hw_data = {mv_user_q, mv_part_q, mv_val_q};
    mr_addr = idx_tab[in_i.user_id];
    mw_en = 1'b0;        mw_addr = '0;      mw_data = '0;
    lc_n = '0;

    if (ov_q && out_o.ready) ov_d = 1'b0;

    unique case (state_q)
      S_CLR: begin
        mw_en   = 1'b1;
        mw_addr = clr_q;
        clr_d   = clr_q + UW'(1);
        if (clr_q == ULAST) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_i.valid) begin
          st_d = ihpq_pkg::ST_OK;
          ru_d = '0; rp_d = '0; rv_d = '0;
          wr_mv_d = 1'b0;
          amt_d = in_i.amount;
          state_d = S_FIN;
          unique case (in_i.operation)
            ihpq_pkg::OP_INSERT: begin
              if (cnt_q == CAP_C) begin
                st_d = ihpq_pkg::ST_FULL;
              end else begin
                mv_user_d = in_i.user_id;
                mv_part_d = in_i.partner_id;
                mv_val_d  = sat_f(DW'(in_i.new_value));
                slot_d    = cnt_q[SW-1:0];
                cnt_d     = cnt_q + CW'(1);
                wr_mv_d   = 1'b1;
                mw_en     = 1'b1;
                mw_addr   = idx_tab[in_i.user_id];
                mw_data   = {1'b1, cnt_q[SW-1:0]};
                hr_a_addr = SW'((cnt_q[SW-1:0] - SW'(1)) >> 1);
                if (cnt_q != '0) state_d = S_UP_RD;
              end
            end
            ihpq_pkg::OP_EXTRACT: begin
              if (cnt_q == '0) begin
                st_d = ihpq_pkg::ST_EMPTY;
              end else begin
                hr_a_addr = '0;
                hr_b_addr = SW'(cnt_q - CW'(1));
                state_d   = S_EXT_RD;
              end
            end
            ihpq_pkg::OP_CHANGE: begin
              state_d = S_CHG_MAP;
            end
            default: ;
          endcase
        end
      end
      S_EXT_RD: begin
        ru_d = a_user;
        rp_d = a_part;
        rv_d = ihpq_pkg::NumW'(DW'(a_val));
        mw_en   = 1'b1;
        mw_addr = idx_tab[a_user];
        mw_data = '0;
        cnt_d   = cnt_q - CW'(1);
        mv_user_d = b_user;
        mv_part_d = hr_b_data[VB +: IW];
        mv_val_d  = b_val;
        slot_d    = '0;
        if (cnt_q == CW'(1)) begin
          state_d = S_FIN;
        end else begin
          wr_mv_d = 1'b1;
          state_d = S_EXT_REC;
        end
      end
      S_EXT_REC: begin
        // moved leaf now sits at the root
        mw_en     = 1'b1;
        mw_addr   = idx_tab[mv_user_q];
        mw_data   = {1'b1, slot_q};
        hr_a_addr = lc[SW-1:0];
        hr_b_addr = rc[SW-1:0];
        state_d   = l_ok ? S_DN_RD : S_FIN;
      end
      S_CHG_MAP: begin
        if (!mr_data[MW-1] || CW'(mr_data[SW-1:0]) >= cnt_q) begin
          st_d    = ihpq_pkg::ST_ABSENT;
          state_d = S_FIN;
        end else begin
          slot_d    = mr_data[SW-1:0];
          hr_a_addr = mr_data[SW-1:0];
          state_d   = S_CHG_RD;
        end
      end
      S_CHG_RD: begin
        mv_user_d = a_user;
        mv_part_d = a_part;
        mv_val_d  = nw;
        wr_mv_d   = 1'b1;
        if (nw > a_val) begin
          hr_a_addr = up_slot;
          state_d   = (slot_q == '0) ? S_FIN : S_UP_RD;
        end else begin
          hr_a_addr = lc[SW-1:0];
          hr_b_addr = rc[SW-1:0];
          state_d   = l_ok ? S_DN_RD : S_FIN;
        end
      end
      S_UP_RD: begin
        if (a_val < mv_val_q) begin
          hw_en     = 1'b1;
          hw_addr   = slot_q;
          hw_data   = hr_a_data;
          mw_en     = 1'b1;
          mw_addr   = idx_tab[mv_user_q];
          mw_data   = {1'b1, up_slot};
          sw_user_d = a_user;
          sw_slot_d = slot_q;
          slot_d    = up_slot;
          state_d   = S_UP_W2;
        end else begin
          state_d = S_FIN;
        end
      end
      S_UP_W2: begin
        mw_en     = 1'b1;
        mw_addr   = idx_tab[sw_user_q];
        mw_data   = {1'b1, sw_slot_q};
        hr_a_addr = up_slot;
        state_d   = (slot_q == '0) ? S_FIN : S_UP_RD;
      end
      S_DN_RD: begin
        if (pick_l || pick_r) begin
          hw_en   = 1'b1;
          hw_addr = slot_q;
          hw_data = pick_r ? hr_b_data : hr_a_data;
          mw_en   = 1'b1;
          mw_addr = idx_tab[pick_r ? b_user : a_user];
          mw_data = {1'b1, slot_q};
          slot_d  = pick_r ? rc[SW-1:0] : lc[SW-1:0];
          state_d = S_DN_W2;
        end else begin
          state_d = S_FIN;
        end
      end
      S_DN_W2: begin
        mw_en     = 1'b1;
        mw_addr   = idx_tab[mv_user_q];
        mw_data   = {1'b1, slot_q};
        lc_n      = lc;
        hr_a_addr = lc_n[SW-1:0];
        hr_b_addr = rc[SW-1:0];
        state_d   = l_ok ? S_DN_RD : S_FIN;
      end
      S_FIN: begin
        hw_en = wr_mv_q;
        if (!ov_q || out_o.ready) begin
          ov_d    = 1'b1;
          o_st_d  = st_q;
          o_u_d   = ru_q;
          o_p_d   = rp_q;
          o_v_d   = rv_q;
          o_occ_d = ihpq_pkg::OccW'(cnt_q);
          wr_mv_d = 1'b0;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      clr_q   <= '0;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
      wr_mv_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      cnt_q   <= cnt_d;
      ov_q    <= ov_d;
      wr_mv_q <= wr_mv_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    slot_q    <= slot_d;
    sw_slot_q <= sw_slot_d;
    sw_user_q <= sw_user_d;
    mv_user_q <= mv_user_d;
    mv_part_q <= mv_part_d;
    mv_val_q  <= mv_val_d;
    amt_q     <= amt_d;
    st_q      <= st_d;
    ru_q      <= ru_d;
    rp_q      <= rp_d;
    rv_q      <= rv_d;
    o_st_q    <= o_st_d;
    o_u_q     <= o_u_d;
    o_p_q     <= o_p_d;
    o_v_q     <= o_v_d;
    o_occ_q   <= o_occ_d;
  end

endmodule

// ===== hw/rtl/ihpq_checker.sv =====
// Port-level checks for the heap queue
module ihpq_port_checks #(
  parameter int unsigned HEAP_CAPACITY = ihpq_pkg::HeapCapacityDef
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [ihpq_pkg::StatW-1:0]       status,
  input logic [ihpq_pkg::IdW-1:0]         out_user,
  input logic signed [ihpq_pkg::NumW-1:0] out_value,
  input logic [ihpq_pkg::OccW-1:0]        occupancy
);

  // result transaction holds until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(occupancy))
    else $error("result dropped or changed while stalled");

  // empty heap reports zero occupancy and no entry
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && status == ihpq_pkg::ST_EMPTY |-> occupancy == '0 && out_value == '0)
    else $error("empty status with entries");

  // full heap reports capacity
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && status == ihpq_pkg::ST_FULL |->
      occupancy == ihpq_pkg::OccW'(HEAP_CAPACITY) && out_user == '0)
    else $error("full status below capacity");

  // occupancy never exceeds capacity
  a_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> 32'(occupancy) <= 32'(HEAP_CAPACITY))
    else $error("occupancy above capacity");

endmodule

bind indexed_max_heap_priority_queue ihpq_port_checks #(.HEAP_CAPACITY(HEAP_CAPACITY)) u_ihpq_chk (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .status    (out_o.status),
  .out_user  (out_o.out_user),
  .out_value (out_o.out_value),
  .occupancy (out_o.occupancy)
);
